// ----- src/trtp_pkg.sv -----
// shared types and constants for the task runtime top-n profiler
// no dependencies

package trtp_pkg;

  localparam int unsigned IdW        = 22;
  localparam int unsigned StampW     = 64;
  localparam int unsigned TaskSlots  = 64;
  localparam int unsigned ReportCnt  = 10;

  typedef enum logic {
    KIND_SWITCH = 1'b0,
    KIND_REPORT = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [IdW-1:0]     prev_id;
    logic [IdW-1:0]     next_id;
    logic [StampW-1:0]  now;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_out_t;

endpackage

// ----- src/trtp_front.sv -----
// front end: accepts input transfers, drops ignored switch events, queues the rest
// depends on trtp_pkg

module trtp_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            action_i,
  input  logic [trtp_pkg::IdW-1:0]        prev_task_id_i,
  input  logic [trtp_pkg::IdW-1:0]        next_task_id_i,
  input  logic [trtp_pkg::StampW-1:0]     now_stamp_i,
  input  logic                            kernel_context_i,
  output trtp_pkg::queue_out_t            q_o,
  input  logic                            pop_i
);

  trtp_pkg::item_t entry_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      count_q, count_d;
  logic            push;
  logic            keep;
  trtp_pkg::item_t new_item;

  always_comb begin
    new_item.kind    = action_i ? trtp_pkg::KIND_REPORT : trtp_pkg::KIND_SWITCH;
    new_item.prev_id = prev_task_id_i;
    new_item.next_id = next_task_id_i;
    new_item.now     = now_stamp_i;
    keep = action_i || (!kernel_context_i && (prev_task_id_i != next_task_id_i));
  end

  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o && keep;
  assign q_o.valid  = (count_q != 2'd0);
  assign q_o.item   = entry_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !(pop_i && q_o.valid)) begin
      count_d = count_q + 2'd1;
    end else if (!push && pop_i && q_o.valid) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i && q_o.valid) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

// ----- src/trtp_back.sv -----
// back end: slot table sequencer for switch accounting and top-n reports
// depends on trtp_pkg

module trtp_back #(
  parameter int unsigned TASK_SLOTS   = trtp_pkg::TaskSlots,
  parameter int unsigned REPORT_COUNT = trtp_pkg::ReportCnt
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  trtp_pkg::queue_out_t            q_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [trtp_pkg::IdW-1:0]        task_id_o,
  output logic [trtp_pkg::StampW-1:0]     total_cycles_o,
  output logic                            entry_valid_o,
  output logic                            last_o
);

  localparam int unsigned IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned CW = $clog2(REPORT_COUNT + 1);
  localparam int unsigned SW = trtp_pkg::StampW;
  localparam int unsigned DW = trtp_pkg::IdW;
  localparam logic [IW:0] SlotsN = (IW+1)'(TASK_SLOTS);
  localparam logic [CW-1:0] ReportN = CW'(REPORT_COUNT);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [DW-1:0] mem_task  [TASK_SLOTS];
  logic [SW-1:0] mem_start [TASK_SLOTS];
  logic [SW:0]   mem_total [TASK_SLOTS];

  logic [DW-1:0] rd_task_q;
  logic [SW-1:0] rd_start_q;
  logic [SW:0]   rd_total_q;
  logic [IW-1:0] rd_addr;

  logic          task_we, start_we, total_we;
  logic [IW-1:0] task_wa, start_wa, total_wa;
  logic [DW-1:0] task_wd;
  logic [SW-1:0] start_wd;
  logic [SW:0]   total_wd;

  logic [2:0]      state_q, state_d;
  trtp_pkg::item_t cur_q, cur_d;
  logic [IW:0]     fill_q, fill_d;
  logic [IW:0]     issue_q, issue_d;
  logic            pv_q, pv_d;
  logic [IW-1:0]   pidx_q, pidx_d;
  logic            pf_v_q, pf_v_d;
  logic [IW-1:0]   pf_idx_q, pf_idx_d;
  logic            nf_v_q, nf_v_d;
  logic [IW-1:0]   nf_idx_q, nf_idx_d;
  logic            best_v_q, best_v_d;
  logic [DW-1:0]   best_id_q, best_id_d;
  logic [SW-1:0]   best_tot_q, best_tot_d;
  logic            prev_v_q, prev_v_d;
  logic [DW-1:0]   prev_id_q, prev_id_d;
  logic [SW-1:0]   prev_tot_q, prev_tot_d;
  logic            pend_v_q, pend_v_d;
  logic [DW-1:0]   pend_id_q, pend_id_d;
  logic [SW-1:0]   pend_tot_q, pend_tot_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  logic            out_v_q, out_v_d;
  logic [DW-1:0]   out_id_q, out_id_d;
  logic [SW-1:0]   out_tot_q, out_tot_d;
  logic            out_ev_q, out_ev_d;
  logic            out_last_q, out_last_d;
  logic            out_free;

  logic            scan_done;
  logic            cand_ok, cand_better;
  logic [SW-1:0]   delta;
  logic [SW:0]     sum;

  assign out_free       = !out_v_q || !out_stall_i;
  assign out_valid_o    = out_v_q;
  assign task_id_o      = out_id_q;
  assign total_cycles_o = out_tot_q;
  assign entry_valid_o  = out_ev_q;
  assign last_o         = out_last_q;

  assign scan_done = (issue_q == fill_q) && !pv_q;

  always_comb begin
    cand_ok = rd_total_q[SW] && (!prev_v_q || (rd_total_q[SW-1:0] < prev_tot_q) ||
              ((rd_total_q[SW-1:0] == prev_tot_q) && (rd_task_q > prev_id_q)));
    cand_better = !best_v_q || (rd_total_q[SW-1:0] > best_tot_q) ||
                  ((rd_total_q[SW-1:0] == best_tot_q) && (rd_task_q < best_id_q));
    delta = cur_q.now - rd_start_q;
    sum   = {1'b0, rd_total_q[SW-1:0]} + {1'b0, delta};
  end

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    fill_d     = fill_q;
    issue_d    = issue_q;
    pv_d       = 1'b0;
    pidx_d     = pidx_q;
    pf_v_d     = pf_v_q;
    pf_idx_d   = pf_idx_q;
    nf_v_d     = nf_v_q;
    nf_idx_d   = nf_idx_q;
    best_v_d   = best_v_q;
    best_id_d  = best_id_q;
    best_tot_d = best_tot_q;
    prev_v_d   = prev_v_q;
    prev_id_d  = prev_id_q;
    prev_tot_d = prev_tot_q;
    pend_v_d   = pend_v_q;
    pend_id_d  = pend_id_q;
    pend_tot_d = pend_tot_q;
    cnt_d      = cnt_q;
    out_v_d    = out_v_q && out_stall_i;
    out_id_d   = out_id_q;
    out_tot_d  = out_tot_q;
    out_ev_d   = out_ev_q;
    out_last_d = out_last_q;
    pop_o      = 1'b0;
    rd_addr    = issue_q[IW-1:0];
    task_we    = 1'b0;
    task_wa    = fill_q[IW-1:0];
    task_wd    = cur_q.next_id;
    start_we   = 1'b0;
    start_wa   = fill_q[IW-1:0];
    start_wd   = cur_q.now;
    total_we   = 1'b0;
    total_wa   = fill_q[IW-1:0];
    total_wd   = '0;

    unique case (state_q)
      ST_IDLE: begin
        pop_o = q_i.valid;
        if (q_i.valid) begin
          cur_d    = q_i.item;
          issue_d  = '0;
          pf_v_d   = 1'b0;
          nf_v_d   = 1'b0;
          best_v_d = 1'b0;
          prev_v_d = 1'b0;
          pend_v_d = 1'b0;
          cnt_d    = '0;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue_q != fill_q) begin
          issue_d = issue_q + 1'b1;
          pv_d    = 1'b1;
          pidx_d  = issue_q[IW-1:0];
        end
        if (pv_q) begin
          if (cur_q.kind == trtp_pkg::KIND_SWITCH) begin
            if (rd_task_q == cur_q.next_id) begin
              nf_v_d   = 1'b1;
              nf_idx_d = pidx_q;
            end
            if (rd_task_q == cur_q.prev_id) begin
              pf_v_d   = 1'b1;
              pf_idx_d = pidx_q;
            end
          end else if (cand_ok && cand_better) begin
            best_v_d   = 1'b1;
            best_id_d  = rd_task_q;
            best_tot_d = rd_total_q[SW-1:0];
          end
        end
        if (scan_done) begin
          if (cur_q.kind == trtp_pkg::KIND_SWITCH) begin
            if (nf_v_q) begin
              start_we = 1'b1;
              start_wa = nf_idx_q;
            end else if (fill_q != SlotsN) begin
              task_we  = 1'b1;
              start_we = 1'b1;
              total_we = 1'b1;
              fill_d   = fill_q + 1'b1;
            end
            state_d = pf_v_q ? ST_RD : ST_IDLE;
          end else begin
            state_d = best_v_q ? ST_EMIT : ST_FIN;
          end
        end
      end
      ST_RD: begin
        rd_addr = pf_idx_q;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (rd_start_q != '0) begin
          total_we = 1'b1;
          total_wa = pf_idx_q;
          if (!rd_total_q[SW]) begin
            total_wd = {1'b1, delta};
          end else if (sum[SW]) begin
            total_wd = {1'b1, {SW{1'b1}}};
          end else begin
            total_wd = {1'b1, sum[SW-1:0]};
          end
        end
        state_d = ST_IDLE;
      end
      ST_EMIT: begin
        if (out_free) begin
          if (pend_v_q) begin
            out_v_d    = 1'b1;
            out_id_d   = pend_id_q;
            out_tot_d  = pend_tot_q;
            out_ev_d   = 1'b1;
            out_last_d = 1'b0;
          end
          pend_v_d   = 1'b1;
          pend_id_d  = best_id_q;
          pend_tot_d = best_tot_q;
          prev_v_d   = 1'b1;
          prev_id_d  = best_id_q;
          prev_tot_d = best_tot_q;
          best_v_d   = 1'b0;
          issue_d    = '0;
          cnt_d      = cnt_q + 1'b1;
          state_d    = (cnt_d == ReportN) ? ST_FIN : ST_SCAN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_v_d    = 1'b1;
          out_id_d   = pend_v_q ? pend_id_q : '0;
          out_tot_d  = pend_v_q ? pend_tot_q : '0;
          out_ev_d   = pend_v_q;
          out_last_d = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fill_q   <= '0;
      issue_q  <= '0;
      pv_q     <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      issue_q  <= issue_d;
      pv_q     <= pv_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    pidx_q     <= pidx_d;
    pf_v_q     <= pf_v_d;
    pf_idx_q   <= pf_idx_d;
    nf_v_q     <= nf_v_d;
    nf_idx_q   <= nf_idx_d;
    best_v_q   <= best_v_d;
    best_id_q  <= best_id_d;
    best_tot_q <= best_tot_d;
    prev_v_q   <= prev_v_d;
    prev_id_q  <= prev_id_d;
    prev_tot_q <= prev_tot_d;
    pend_v_q   <= pend_v_d;
    pend_id_q  <= pend_id_d;
    pend_tot_q <= pend_tot_d;
    cnt_q      <= cnt_d;
    out_id_q   <= out_id_d;
    out_tot_q  <= out_tot_d;
    out_ev_q   <= out_ev_d;
    out_last_q <= out_last_d;
  end

  // slot table memories
  always_ff @(posedge clk_i) begin
    if (task_we) begin
      mem_task[task_wa] <= task_wd;
    end
    if (start_we) begin
      mem_start[start_wa] <= start_wd;
    end
    if (total_we) begin
      mem_total[total_wa] <= total_wd;
    end
    rd_task_q  <= mem_task[rd_addr];
    rd_start_q <= mem_start[rd_addr];
    rd_total_q <= mem_total[rd_addr];
  end

endmodule

// ----- src/task_runtime_top_n_profiler.sv -----
// top level of the task runtime top-n profiler
// depends on trtp_pkg, trtp_front and trtp_back
//
// input channel (in_valid_i / in_stall_o) carries context switch events and
// report requests; output channel (out_valid_o / out_stall_i) carries report
// results, one per transfer, the final one of a report with last_o set.
// the front end drops ignored switch events and queues up to two items, so
// in_stall_o rises only when that queue is full.
// a switch event walks the slot table, one entry a cycle through a registered
// memory read, over the claimed slots; when the outgoing task is found, its
// total is then read and updated in the ST_RD and ST_UPD states.
// a report makes up to REPORT_COUNT walks, one per reported task, then a
// closing walk unless REPORT_COUNT tasks were found, and a finish state;
// each task's result is loaded one walk after it is found, the final one in
// the finish state.
// reset empties the queue and the table fill count at once; no clearing pass.
// a stalled output holds its result and the sequencer waits behind it.

module task_runtime_top_n_profiler #(
  parameter int unsigned TASK_SLOTS   = trtp_pkg::TaskSlots,
  parameter int unsigned REPORT_COUNT = trtp_pkg::ReportCnt
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            action_i,
  input  logic [trtp_pkg::IdW-1:0]        prev_task_id_i,
  input  logic [trtp_pkg::IdW-1:0]        next_task_id_i,
  input  logic [trtp_pkg::StampW-1:0]     now_stamp_i,
  input  logic                            kernel_context_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [trtp_pkg::IdW-1:0]        task_id_o,
  output logic [trtp_pkg::StampW-1:0]     total_cycles_o,
  output logic                            entry_valid_o,
  output logic                            last_o
);

  trtp_pkg::queue_out_t q;
  logic                 pop;

  trtp_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .prev_task_id_i   (prev_task_id_i),
    .next_task_id_i   (next_task_id_i),
    .now_stamp_i      (now_stamp_i),
    .kernel_context_i (kernel_context_i),
    .q_o              (q),
    .pop_i            (pop)
  );

  trtp_back #(
    .TASK_SLOTS   (TASK_SLOTS),
    .REPORT_COUNT (REPORT_COUNT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_i            (q),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .task_id_o      (task_id_o),
    .total_cycles_o (total_cycles_o),
    .entry_valid_o  (entry_valid_o),
    .last_o         (last_o)
  );

endmodule

// ----- src/trtp_checker.sv -----
// port-level checks for the task runtime top-n profiler
// depends on trtp_pkg; bound to task_runtime_top_n_profiler

module trtp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [trtp_pkg::IdW-1:0]    task_id_o,
  input logic [trtp_pkg::StampW-1:0] total_cycles_o,
  input logic                        entry_valid_o,
  input logic                        last_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(task_id_o) &&
      $stable(total_cycles_o) && $stable(entry_valid_o) && $stable(last_o))
    else $error("stalled result changed");

  // an empty report is a single final result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !entry_valid_o |-> last_o)
    else $error("empty result without last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !entry_valid_o |-> (task_id_o == '0) && (total_cycles_o == '0))
    else $error("empty result with payload");

  // an empty result never follows a non-final entry of the same report
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> !out_valid_o || entry_valid_o)
    else $error("report broken by empty result");

endmodule

bind task_runtime_top_n_profiler trtp_checker u_trtp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .task_id_o      (task_id_o),
  .total_cycles_o (total_cycles_o),
  .entry_valid_o  (entry_valid_o),
  .last_o         (last_o)
);

// ----- tb/task_runtime_top_n_profiler_test.sv -----
// testbench for task_runtime_top_n_profiler: directed and random switch events
// and report requests, results checked against a behavioural runtime table
// depends on trtp_pkg and the profiler rtl
`timescale 1ns / 1ps

module task_runtime_top_n_profiler_test;

  typedef struct {
    logic [trtp_pkg::IdW-1:0]    id;
    logic [trtp_pkg::StampW-1:0] total;
    logic                        ent;
    logic                        lst;
  } report_row_t;

  class runtime_board;
    logic [trtp_pkg::IdW-1:0]    tid   [trtp_pkg::TaskSlots];
    bit                          used  [trtp_pkg::TaskSlots];
    logic [trtp_pkg::StampW-1:0] start [trtp_pkg::TaskSlots];
    logic [trtp_pkg::StampW-1:0] total [trtp_pkg::TaskSlots];
    bit                          has   [trtp_pkg::TaskSlots];
    report_row_t                 pending[$];
    int                          errors;

    function new();
      errors = 0;
      foreach (used[i]) begin
        used[i] = 0; start[i] = '0; has[i] = 0; tid[i] = '0; total[i] = '0;
      end
    endfunction

    function int lookup(logic [trtp_pkg::IdW-1:0] id);
      for (int i = 0; i < trtp_pkg::TaskSlots; i++)
        if (used[i] && tid[i] == id) return i;
      return -1;
    endfunction

    function void note_item(trtp_pkg::kind_e k, logic [trtp_pkg::IdW-1:0] p,
                            logic [trtp_pkg::IdW-1:0] n,
                            logic [trtp_pkg::StampW-1:0] now, logic kern);
      int ni, pi, cnt, best;
      bit taken[trtp_pkg::TaskSlots];
      logic [trtp_pkg::StampW-1:0] d, s;
      report_row_t r;
      if (k == trtp_pkg::KIND_REPORT) begin
        foreach (taken[i]) taken[i] = 0;
        cnt = 0;
        while (cnt < trtp_pkg::ReportCnt) begin
          best = -1;
          for (int i = 0; i < trtp_pkg::TaskSlots; i++) begin
            if (!has[i] || taken[i]) continue;
            if (best < 0 || total[i] > total[best] ||
                (total[i] == total[best] && tid[i] < tid[best])) best = i;
          end
          if (best < 0) break;
          taken[best] = 1;
          r.id = tid[best]; r.total = total[best]; r.ent = 1; r.lst = 0;
          pending.push_back(r);
          cnt++;
        end
        if (cnt == 0) begin
          r.id = '0; r.total = '0; r.ent = 0; r.lst = 1;
          pending.push_back(r);
        end else pending[$].lst = 1;
        return;
      end
      if (kern || p == n) return;
      ni = lookup(n);
      if (ni < 0) begin
        for (int i = 0; i < trtp_pkg::TaskSlots; i++) if (!used[i]) begin
          used[i] = 1; tid[i] = n; start[i] = '0; has[i] = 0; ni = i; break;
        end
      end
      if (ni >= 0) start[ni] = now;
      pi = lookup(p);
      if (pi >= 0 && start[pi] != 0) begin
        d = now - start[pi];
        if (has[pi]) begin
          s = total[pi] + d;
          total[pi] = (s < d) ? '1 : s;
        end else begin
          total[pi] = d; has[pi] = 1;
        end
      end
    endfunction

    function void check_row(logic [trtp_pkg::IdW-1:0] id,
                            logic [trtp_pkg::StampW-1:0] tot, logic ent, logic lst);
      report_row_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected result id %0h total %0h", $time, id, tot);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (id !== e.id || tot !== e.total || ent !== e.ent || lst !== e.lst) begin
        $display("%0t expected id %0h total %0h valid %0b last %0b", $time,
                 e.id, e.total, e.ent, e.lst);
        $display("%0t actual   id %0h total %0h valid %0b last %0b", $time,
                 id, tot, ent, lst);
        errors++;
      end
    endfunction
  endclass

  logic                        clk_i = 0, rst_ni = 0;
  logic                        in_valid_i = 0, action_i = 0, kernel_context_i = 0;
  logic [trtp_pkg::IdW-1:0]    prev_task_id_i = '0, next_task_id_i = '0;
  logic [trtp_pkg::StampW-1:0] now_stamp_i = '0;
  logic                        out_stall_i = 0;
  logic                        in_stall_o, out_valid_o, entry_valid_o, last_o;
  logic [trtp_pkg::IdW-1:0]    task_id_o;
  logic [trtp_pkg::StampW-1:0] total_cycles_o;

  runtime_board board = new();
  logic [trtp_pkg::IdW-1:0] pool[16];
  logic [trtp_pkg::StampW-1:0] clock_now = 64'd1000;
  bit stall_on = 1;

  task_runtime_top_n_profiler dut (.*);

  initial forever #2 clk_i = ~clk_i;

  initial begin
    #20_000_000;
    $display("task_runtime_top_n_profiler: mismatch");
    $finish;
  end

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i)
      board.check_row(task_id_o, total_cycles_o, entry_valid_o, last_o);
    if (!stall_on) out_stall_i <= 1'b0;
    else case ($urandom_range(0, 3))
      0: out_stall_i <= 1'($urandom_range(0, 1));
      1: out_stall_i <= ($urandom_range(0, 7) == 0);
      default: out_stall_i <= 1'b0;
    endcase
  end

  task send(trtp_pkg::kind_e k, logic [trtp_pkg::IdW-1:0] p,
            logic [trtp_pkg::IdW-1:0] n, logic [trtp_pkg::StampW-1:0] t, logic kern);
    in_valid_i <= 1; action_i <= k; prev_task_id_i <= p; next_task_id_i <= n;
    now_stamp_i <= t; kernel_context_i <= kern;
    do @(posedge clk_i); while (in_stall_o);
    board.note_item(k, p, n, t, kern);
  endtask

  task pause(int n);
    if (n > 0) begin
      in_valid_i <= 0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task drain();
    if (board.pending.size() != 0) begin
      in_valid_i <= 0;
      while (board.pending.size() != 0) @(posedge clk_i);
    end
  endtask

  function logic [trtp_pkg::IdW-1:0] pick_id();
    if ($urandom_range(0, 9) == 0) return trtp_pkg::IdW'($urandom);
    return pool[$urandom_range(0, 15)];
  endfunction

  initial begin
    logic [trtp_pkg::IdW-1:0] cur, nx;
    int burst, r;
    foreach (pool[i]) pool[i] = trtp_pkg::IdW'($urandom);
    pool[0] = '0; pool[1] = '1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // empty report, ignored events
    send(trtp_pkg::KIND_REPORT, '1, '1, '1, 1'b1);
    send(trtp_pkg::KIND_SWITCH, 22'd5, 22'd5, 64'd10, 1'b0);
    send(trtp_pkg::KIND_SWITCH, 22'd1, 22'd2, 64'd10, 1'b1);
    send(trtp_pkg::KIND_SWITCH, 22'd9, 22'd0, 64'd0, 1'b0);    // zero stamp on id 0
    send(trtp_pkg::KIND_SWITCH, 22'd0, '1, 64'd50, 1'b0);      // charges nothing
    send(trtp_pkg::KIND_SWITCH, '1, 22'd0, 64'd80, 1'b0);
    send(trtp_pkg::KIND_SWITCH, 22'd0, 22'd7, 64'd110, 1'b0);  // id 0 charged
    send(trtp_pkg::KIND_SWITCH, 22'd7, '1, 64'd140, 1'b0);     // tie with max id
    send(trtp_pkg::KIND_SWITCH, 22'd3, 22'd4, 64'd200, 1'b0);  // unknown prev
    send(trtp_pkg::KIND_SWITCH, 22'd4, 22'd8, 64'hFFFF_FFFF_FFFF_FFF0, 1'b0);
    send(trtp_pkg::KIND_SWITCH, 22'd8, 22'd4, 64'd5, 1'b0);    // wraps
    send(trtp_pkg::KIND_SWITCH, 22'd4, 22'd8, 64'h8000_0000_0000_0005, 1'b0);
    send(trtp_pkg::KIND_SWITCH, 22'd8, 22'd4, 64'd3, 1'b0);
    send(trtp_pkg::KIND_SWITCH, 22'd4, 22'd8, 64'h8000_0000_0000_0003, 1'b0);
    send(trtp_pkg::KIND_SWITCH, 22'd8, 22'd4, 64'd2, 1'b0);
    send(trtp_pkg::KIND_SWITCH, 22'd4, 22'd8, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0); // saturates
    send(trtp_pkg::KIND_REPORT, 22'd0, 22'd0, 64'd0, 1'b0);
    drain();
    // fill the table past its size
    for (int i = 0; i < 70; i++) begin
      clock_now += 64'($urandom_range(1, 500));
      send(trtp_pkg::KIND_SWITCH, trtp_pkg::IdW'(100 + i), trtp_pkg::IdW'(101 + i),
           clock_now, 1'b0);
    end
    send(trtp_pkg::KIND_REPORT, '0, '0, '0, 1'b0);
    drain();
    // random phase
    cur = pool[2];
    for (int i = 0; i < 20; i += burst) begin
      burst = $urandom_range(1, 12);
      stall_on = ($urandom_range(0, 3) != 0);
      for (int j = 0; j < burst; j++) begin
        r = $urandom_range(0, 19);
        clock_now += 64'($urandom_range(1, 2000));
        if (r < 3) send(trtp_pkg::KIND_REPORT, trtp_pkg::IdW'($urandom),
                        trtp_pkg::IdW'($urandom), {$urandom, $urandom},
                        1'($urandom_range(0, 1)));
        else if (r == 3) send(trtp_pkg::KIND_SWITCH, pick_id(), pick_id(),
                              {$urandom, $urandom}, 1'($urandom_range(0, 1)));
        else if (r == 4) send(trtp_pkg::KIND_SWITCH, cur, cur, clock_now, 1'b0);
        else begin
          nx = pick_id();
          send(trtp_pkg::KIND_SWITCH, cur, nx, clock_now, ($urandom_range(0, 15) == 0));
          cur = nx;
        end
      end
      if ($urandom_range(0, 5) == 0) drain();
      else pause($urandom_range(0, 20));
    end
    send(trtp_pkg::KIND_REPORT, '0, '0, '0, 1'b0);
    drain();
    repeat (2000) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("task_runtime_top_n_profiler: match");
    else
      $display("task_runtime_top_n_profiler: mismatch");
    $finish;
  end
endmodule
